// ----- hw/rtl/lru_page_replacement_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LRU page replacement unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LRUPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Payload types and fixed widths shared by the replacement unit modules.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CAP_BITS   = 4;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 last_access;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] access_count;
    logic                  stream_end;
  } res_t;

  // Outcome of one lookup, passed from the frame store to the statistics.
  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
  } lookup_t;

endpackage

// ----- hw/rtl/lrupr_frame_store.sv -----
// ----------------------------------------------------------------------------
// LRU frame store
// Page frames with recency ranks; parallel tag compare and rank update.
// ----------------------------------------------------------------------------
module lrupr_frame_store import lrupr_pkg::*; #(
  parameter int unsigned FRAMES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  req_t                req_i,
  input  logic [CAP_BITS-1:0] cap_i,
  output lookup_t             lookup_o
);

  `include "lru_page_replacement_unit_macros.svh"

  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned OW = $clog2(FRAMES + 1);
  localparam int unsigned CW = (OW > CAP_BITS) ? OW : CAP_BITS;

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [RW-1:0]        rank_q [FRAMES];
  logic [RW-1:0]        rank_d [FRAMES];
  logic [OW-1:0]        occ_q, occ_d;

  logic [FRAMES-1:0]    valid, hit_vec, lru_vec, ins_vec, tgt_vec;
  logic [RW-1:0]        hit_rank, lru_rank, age_limit;
  logic [PAGE_BITS-1:0] ev_page;
  logic [CW-1:0]        cap_ext, cap_eff;
  logic                 do_hit, do_ins, do_ev;

  // Capacity zero acts as one and anything above the built size as the size.
  always_comb begin
    cap_ext = CW'(cap_i);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(FRAMES)) begin
      cap_eff = CW'(FRAMES);
    end
  end

  // Frames fill from the bottom and are only freed together, so the valid
  // frames are always those below the occupancy count.
  assign lru_rank = RW'(occ_q - OW'(1));

  always_comb begin
    hit_rank = '0;
    ev_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      valid[i]   = OW'(i) < occ_q;
      hit_vec[i] = valid[i] && (page_q[i] == req_i.page);
      lru_vec[i] = valid[i] && (rank_q[i] == lru_rank);
      ins_vec[i] = OW'(i) == occ_q;
      hit_rank   = hit_rank | (rank_q[i] & {RW{hit_vec[i]}});
      ev_page    = ev_page | (page_q[i] & {PAGE_BITS{lru_vec[i]}});
    end
  end

  assign do_hit = |hit_vec;
  assign do_ins = !do_hit && (CW'(occ_q) < cap_eff);
  assign do_ev  = !do_hit && !do_ins;

  assign tgt_vec   = do_hit ? hit_vec : (do_ins ? ins_vec : lru_vec);
  assign age_limit = do_hit ? hit_rank : lru_rank;

  always_comb begin
    occ_d = occ_q;
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (valid[i] && (do_ins || (rank_q[i] < age_limit))) begin
        rank_d[i] = rank_q[i] + RW'(1);
      end
      if (tgt_vec[i]) begin
        rank_d[i] = '0;
      end
    end
    if (do_ins) begin
      occ_d = occ_q + OW'(1);
    end
    if (req_i.last_access) begin
      occ_d = '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (vld_i) begin
      occ_q  <= occ_d;
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAMES; i++) begin
      if (vld_i && !do_hit && tgt_vec[i]) begin
        page_q[i] <= req_i.page;
      end
    end
  end

  assign lookup_o.hit           = do_hit;
  assign lookup_o.evicted_valid = do_ev;
  assign lookup_o.evicted_page  = do_ev ? ev_page : '0;

  `LRUPR_ASSERT(a_occ_range, occ_q <= OW'(FRAMES), "occupancy above frame count")
  `LRUPR_ASSERT(a_hit_unique, $onehot0(hit_vec), "page resident in two frames")
  `LRUPR_ASSERT(a_lru_found, (occ_q == '0) || $onehot(lru_vec),
                "no unique least recent frame")

endmodule

// ----- hw/rtl/lrupr_stats.sv -----
// ----------------------------------------------------------------------------
// LRU statistics and result register
// Saturating hit and access counters per stream; registers each result.
// ----------------------------------------------------------------------------
module lrupr_stats import lrupr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  logic    last_i,
  input  lookup_t lookup_i,
  output logic    res_valid_o,
  output res_t    res_o
);

  `include "lru_page_replacement_unit_macros.svh"

  logic [COUNT_BITS-1:0] hits_q, hits_d, acc_q, acc_d, hits_new, acc_new;
  logic                  res_valid_q;
  res_t                  res_q, res_d;

  always_comb begin
    hits_new = hits_q;
    if (lookup_i.hit && (hits_q != '1)) begin
      hits_new = hits_q + COUNT_BITS'(1);
    end
    acc_new = (acc_q != '1) ? acc_q + COUNT_BITS'(1) : acc_q;
    hits_d  = last_i ? '0 : hits_new;
    acc_d   = last_i ? '0 : acc_new;

    res_d.hit           = lookup_i.hit;
    res_d.evicted_valid = lookup_i.evicted_valid;
    res_d.evicted_page  = lookup_i.evicted_page;
    res_d.hit_count     = hits_new;
    res_d.access_count  = acc_new;
    res_d.stream_end    = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vld_i;
      if (vld_i) begin
        hits_q <= hits_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `LRUPR_ASSERT(a_hits_le_acc, !res_valid_q || (res_q.hit_count <= res_q.access_count),
                "hit count exceeds access count")

endmodule

// ----- hw/rtl/lru_page_replacement_unit.sv -----
// Flow: a reference accepted on start_i is registered, looked up in the frame
// store, and its result is registered with a strobe that is high for one cycle.
// Throughput: one reference per cycle; busy_o never rises and the receiver
// cannot stall. The tag compare over all frames sets the cycle time.
// Reset: asynchronous, empties the store, zeroes the counters and sets
// capacity to eight.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative page frame store with least recently used replacement.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit import lrupr_pkg::*; #(
  parameter int unsigned FRAMES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_BITS-1:0] cfg_data_i,
  output logic                res_valid_o,
  output res_t                res_o
);

  `include "lru_page_replacement_unit_macros.svh"

  logic                in_vld_q;
  req_t                req_q;
  logic [CAP_BITS-1:0] cap_q;
  lookup_t             lookup;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      in_vld_q <= start_i && !busy_o;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  lrupr_frame_store #(
    .FRAMES (FRAMES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_vld_q),
    .req_i    (req_q),
    .cap_i    (cap_q),
    .lookup_o (lookup)
  );

  lrupr_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (in_vld_q),
    .last_i      (req_q.last_access),
    .lookup_i    (lookup),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Every accepted transfer yields exactly one result, registered after its lookup.
  `LRUPR_ASSERT_NEXT(a_one_result, in_vld_q, res_valid_o, "result strobe missing")
  `LRUPR_ASSERT_NEXT(a_no_spurious, !in_vld_q, !res_valid_o, "result without a request")

endmodule

// ----- verif/lru_page_replacement_unit_tb.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Drives page references through the command port and checks every result
// strobe against a shadow copy of the frame store, its recency ranks and the
// stream counters. Directed tests cover the page extremes, capacity bounds,
// a capacity cut mid-stream and a run of back-to-back hits. A long random
// phase of well-formed streams over small working sets follows, with gaps.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;
  import lrupr_pkg::*;

  localparam int unsigned FRAMES       = 8;
  localparam int unsigned RANK_BITS    = $clog2(FRAMES);
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 960;
  localparam int unsigned RUN_ITEMS    = 48;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  req_t                req_i       = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_BITS-1:0] cfg_data_i  = '0;
  logic                res_valid_o;
  res_t                res_o;

  // Shadow copy of the frame store, the counters and the capacity register.
  logic [PAGE_BITS-1:0]  shadow_page  [FRAMES];
  logic                  shadow_valid [FRAMES];
  logic [RANK_BITS-1:0]  shadow_rank  [FRAMES];
  logic [COUNT_BITS-1:0] shadow_hits;
  logic [COUNT_BITS-1:0] shadow_accesses;
  logic [CAP_BITS-1:0]   shadow_capacity;

  res_t        pending_results[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          gaps_enabled = 1'b1;

  lru_page_replacement_unit #(
    .FRAMES(FRAMES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void clear_shadow_store();
    for (int i = 0; i < FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    shadow_hits     = '0;
    shadow_accesses = '0;
  endfunction

  // Every occupied frame more recent than the limit moves one place older.
  function automatic void age_frames(int unsigned limit);
    for (int i = 0; i < FRAMES; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < limit) shadow_rank[i] = shadow_rank[i] + 1'b1;
    end
  endfunction

  function automatic res_t predict_lookup(req_t ref_in);
    res_t        res;
    int unsigned eff_cap;
    int unsigned occupied;
    int          hit_idx;
    int          free_idx;
    int          lru_idx;
    res      = '0;
    occupied = 0;
    hit_idx  = -1;
    free_idx = -1;
    lru_idx  = -1;
    if (shadow_capacity == 0) eff_cap = 1;
    else if (shadow_capacity > FRAMES) eff_cap = FRAMES;
    else eff_cap = shadow_capacity;

    for (int i = 0; i < FRAMES; i++) begin
      if (shadow_valid[i]) begin
        occupied++;
        if (shadow_page[i] == ref_in.page) hit_idx = i;
        if (lru_idx < 0 || shadow_rank[i] > shadow_rank[lru_idx]) lru_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end

    if (hit_idx >= 0) begin
      res.hit = 1'b1;
      age_frames(shadow_rank[hit_idx]);
      shadow_rank[hit_idx] = '0;
      if (shadow_hits != '1) shadow_hits = shadow_hits + 1'b1;
    end else if (occupied < eff_cap && free_idx >= 0) begin
      age_frames(FRAMES);
      shadow_page[free_idx]  = ref_in.page;
      shadow_valid[free_idx] = 1'b1;
      shadow_rank[free_idx]  = '0;
    end else if (lru_idx >= 0) begin
      res.evicted_valid = 1'b1;
      res.evicted_page  = shadow_page[lru_idx];
      age_frames(shadow_rank[lru_idx]);
      shadow_page[lru_idx] = ref_in.page;
      shadow_rank[lru_idx] = '0;
    end
    if (shadow_accesses != '1) shadow_accesses = shadow_accesses + 1'b1;

    res.hit_count    = shadow_hits;
    res.access_count = shadow_accesses;
    res.stream_end   = ref_in.last_access;
    if (ref_in.last_access) clear_shadow_store();
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result strobe with no reference outstanding");
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", want.hit, res_o.hit);
        compare_field("evicted_valid", want.evicted_valid, res_o.evicted_valid);
        compare_field("evicted_page", want.evicted_page, res_o.evicted_page);
        compare_field("hit_count", want.hit_count, res_o.hit_count);
        compare_field("access_count", want.access_count, res_o.access_count);
        compare_field("stream_end", want.stream_end, res_o.stream_end);
      end
    end
  end

  // Holds start high until the transfer; start stays high for a follow-on item.
  task automatic issue_reference(input logic [PAGE_BITS-1:0] page, input logic last);
    req_t ref_in;
    ref_in.page        = page;
    ref_in.last_access = last;
    if (start_i !== 1'b1) start_i <= 1'b1;
    req_i <= ref_in;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(predict_lookup(ref_in));
  endtask

  function automatic int unsigned random_gap();
    int unsigned roll;
    if (!gaps_enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      req_i   <= req_t'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic reference_and_idle(input logic [PAGE_BITS-1:0] page, input logic last);
    issue_reference(page, last);
    idle_for(random_gap());
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_capacity = value;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CAP_BITS'($urandom);
    @(posedge clk_i);
  endtask

  // Capacity left at its reset value; page numbers at both extremes.
  task automatic test_reset_capacity();
    reference_and_idle(16'h0000, 1'b0);
    reference_and_idle(16'hFFFF, 1'b0);
    reference_and_idle(16'h0000, 1'b0);
    reference_and_idle(16'hFFFF, 1'b1);
  endtask

  // Zero acts as one frame, fifteen acts as the full frame count.
  task automatic test_capacity_bounds();
    write_capacity(CAP_BITS'(0));
    reference_and_idle(16'hAAAA, 1'b0);
    reference_and_idle(16'hAAAA, 1'b0);
    reference_and_idle(16'h5555, 1'b0);
    reference_and_idle(16'h5555, 1'b1);
    write_capacity(CAP_BITS'(15));
    for (int i = 0; i <= FRAMES; i++) begin
      reference_and_idle(PAGE_BITS'(16'h0100 + i), i == FRAMES);
    end
  endtask

  // Frames already held survive a capacity cut; later misses evict.
  task automatic test_capacity_lowered();
    write_capacity(CAP_BITS'(8));
    for (int i = 0; i < 4; i++) reference_and_idle(PAGE_BITS'(16'h0200 + i), 1'b0);
    write_capacity(CAP_BITS'(1));
    reference_and_idle(16'h0300, 1'b0);
    reference_and_idle(16'h0301, 1'b0);
    reference_and_idle(16'h0200, 1'b1);
  endtask

  // One page repeated without gaps gives a long run of back-to-back hits.
  task automatic test_back_to_back_hits();
    write_capacity(CAP_BITS'(8));
    gaps_enabled = 1'b0;
    for (int n = 0; n < RUN_ITEMS; n++) begin
      issue_reference(16'h1234, n == RUN_ITEMS - 1);
    end
    gaps_enabled = 1'b1;
    drain_results();
  endtask

  task automatic test_random_streams();
    int unsigned          sent;
    int unsigned          len;
    int unsigned          pool_size;
    logic [PAGE_BITS-1:0] pool [16];
    logic [PAGE_BITS-1:0] page;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_capacity(CAP_BITS'($urandom_range(0, 15)));
      else if ($urandom_range(0, 9) == 0) drain_results();
      gaps_enabled = ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(1, 16);
      foreach (pool[i]) pool[i] = PAGE_BITS'($urandom);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 160);
      else len = $urandom_range(1, 40);
      for (int n = 0; n < len; n++) begin
        // Mostly the stream's working set, so hits and evictions both occur.
        if ($urandom_range(0, 9) < 8) page = pool[$urandom_range(0, pool_size - 1)];
        else page = PAGE_BITS'($urandom);
        if (n != 0 && $urandom_range(0, 59) == 0) begin
          write_capacity(CAP_BITS'($urandom_range(0, 15)));
        end
        reference_and_idle(page, n == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    clear_shadow_store();
    shadow_capacity = CAP_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_capacity();
    test_capacity_bounds();
    test_capacity_lowered();
    test_back_to_back_hits();
    test_random_streams();

    drain_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
